>>> hw/rtl/scu_pkg.sv
// Shared types and constants of the spectrum count uncertainty block.
// Used by scu_feed, scu_cell and spectrum_count_uncertainty_top; no dependencies.
`default_nettype none
package scu_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int SIGMA_W    = 28;
  localparam int LIMIT_W    = 8;

  localparam int SUM_RAW = COUNT_BITS + 4;
  localparam int SUM_W   = SUM_RAW + (SUM_RAW % 2);
  localparam int STEPS   = (SUM_W + 2 * FRAC_BITS) / 2;
  localparam int ROOT_W  = STEPS;
  localparam int REM_W   = STEPS + 2;
  localparam int CMP_W   = (ROOT_W > SIGMA_W) ? ROOT_W : SIGMA_W;

  localparam int ADDR_W = 3;
  localparam logic [0:0] IDX_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

  localparam logic [CMP_W-1:0] SIGMA_MAX = CMP_W'((64'd1 << SIGMA_W) - 64'd1);
  localparam logic [63:0] FB_PLAIN_W = (64'd3 << FRAC_BITS) / 64'd10;
  localparam logic [63:0] FB_THREE_W = (64'd5773503 << FRAC_BITS) / 64'd10000000;
  localparam logic [63:0] FB_NINE_W  = (64'd3333333 << FRAC_BITS) / 64'd10000000;
  localparam logic [SIGMA_W-1:0] FB_PLAIN = FB_PLAIN_W[SIGMA_W-1:0];
  localparam logic [SIGMA_W-1:0] FB_THREE = FB_THREE_W[SIGMA_W-1:0];
  localparam logic [SIGMA_W-1:0] FB_NINE  = FB_NINE_W[SIGMA_W-1:0];

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_THREE = 2'd1,
    KIND_NINE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } in_data_t;

  typedef struct packed {
    logic [SIGMA_W-1:0] sigma;
    logic               smoothed;
    logic               final_res;
  } out_data_t;

  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  s;
    logic [3:0]        d;
    logic [3:0]        r;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              zero;
    kind_t             kind;
    logic              fin;
  } stage_t;

endpackage
`default_nettype wire

>>> hw/rtl/scu_feed.sv
// Channel window, position tracking and request issue into the root chain.
// Depends on scu_pkg.
`default_nettype none
module scu_feed (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic [scu_pkg::LIMIT_W-1:0]    limit,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire scu_pkg::in_data_t              in_data,
  output scu_pkg::stage_t                     job_r
);

  typedef logic [4:0][scu_pkg::COUNT_BITS-1:0] win_t;
  typedef enum logic [1:0] {K2 = 2'd0, K3 = 2'd1, K4 = 2'd2} slot_t;

  logic [3:0][scu_pkg::COUNT_BITS-1:0] rc_r, rc_nxt;
  logic [2:0] pos_r, pos_nxt, sj_r, jsel;
  win_t       sv_r, live_v, vsel;
  logic [1:0] pend_r, pend_nxt;
  logic       busy, acc, issue;
  slot_t      k;
  scu_pkg::stage_t job_nxt;

  function automatic logic [scu_pkg::SUM_W-1:0] ext(input logic [scu_pkg::COUNT_BITS-1:0] x);
    ext = scu_pkg::SUM_W'(x);
  endfunction

  function automatic scu_pkg::stage_t mk_job(input win_t v, input slot_t ks,
                                            input logic [2:0] j,
                                            input logic [scu_pkg::LIMIT_W-1:0] lim);
    scu_pkg::stage_t o;
    logic [scu_pkg::COUNT_BITS-1:0] c;
    logic [scu_pkg::SUM_W-1:0] fwd, bwd, mid;
    logic first_two, tail;
    o = '0;
    c = v[2];
    fwd = '0;
    bwd = '0;
    mid = '0;
    first_two = 1'b0;
    tail = 1'b0;
    unique case (ks)
      K2: begin
        c = v[2];
        fwd = ext(v[2]) + ext(v[3]) + ext(v[4]);
        mid = ext(v[0]) + (ext(v[1]) << 1) + (ext(v[2]) << 1) + ext(v[2])
              + (ext(v[3]) << 1) + ext(v[4]);
        first_two = (j < 3'd4);
        tail = 1'b0;
      end
      K3: begin
        c = v[3];
        fwd = ext(v[3]) + ext(v[4]);
        bwd = ext(v[1]) + ext(v[2]) + ext(v[3]);
        first_two = (j < 3'd3);
        tail = 1'b1;
      end
      K4: begin
        c = v[4];
        fwd = ext(v[4]);
        bwd = ext(v[2]) + ext(v[3]) + ext(v[4]);
        first_two = (j < 3'd2);
        tail = 1'b1;
      end
      default: begin
        c = v[2];
      end
    endcase
    if (scu_pkg::COUNT_BITS'(lim) < c || (scu_pkg::COUNT_BITS < scu_pkg::LIMIT_W)) begin
      o.s = ext(c);
      o.d = 4'd1;
      o.kind = scu_pkg::KIND_PLAIN;
    end else if (first_two) begin
      o.s = fwd;
      o.d = 4'd3;
      o.kind = scu_pkg::KIND_THREE;
    end else if (tail) begin
      o.s = bwd;
      o.d = 4'd3;
      o.kind = scu_pkg::KIND_THREE;
    end else begin
      o.s = mid;
      o.d = 4'd9;
      o.kind = scu_pkg::KIND_NINE;
    end
    o.zero = (o.s == '0);
    o.fin = (ks == K4);
    return o;
  endfunction

  assign busy     = (pend_r != 2'b00);
  assign in_ready = adv && !busy;
  assign acc      = in_valid && in_ready;
  assign live_v   = {in_data.count, rc_r[3], rc_r[2], rc_r[1], rc_r[0]};

  always_comb begin
    issue    = 1'b0;
    k        = K2;
    vsel     = live_v;
    jsel     = pos_r;
    pend_nxt = pend_r;
    rc_nxt   = rc_r;
    pos_nxt  = pos_r;
    if (busy) begin
      vsel  = sv_r;
      jsel  = sj_r;
      issue = adv;
      k     = pend_r[0] ? K3 : K4;
      if (adv) begin
        pend_nxt = pend_r[0] ? {pend_r[1], 1'b0} : 2'b00;
      end
    end else if (acc) begin
      if (!in_data.last) begin
        issue   = (pos_r >= 3'd2);
        k       = K2;
        rc_nxt  = {in_data.count, rc_r[3], rc_r[2], rc_r[1]};
        pos_nxt = (pos_r < 3'd4) ? pos_r + 3'd1 : pos_r;
      end else begin
        issue = 1'b1;
        if (pos_r >= 3'd2) begin
          k = K2;
          pend_nxt = 2'b11;
        end else if (pos_r >= 3'd1) begin
          k = K3;
          pend_nxt = 2'b10;
        end else begin
          k = K4;
          pend_nxt = 2'b00;
        end
        rc_nxt  = '0;
        pos_nxt = 3'd0;
      end
    end
    job_nxt = mk_job(vsel, k, jsel, limit);
    job_nxt.valid = issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= '0;
      pos_r       <= 3'd0;
      pend_r      <= 2'b00;
      job_r.valid <= 1'b0;
    end else begin
      rc_r   <= rc_nxt;
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
      if (adv) begin
        job_r <= job_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.last) begin
      sv_r <= live_v;
      sj_r <= pos_r;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/scu_cell.sv
// One step of the combined divide and square root: two quotient bits, one root bit.
// Depends on scu_pkg.
`default_nettype none
module scu_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire scu_pkg::stage_t st_in,
  output scu_pkg::stage_t      st_r
);

  scu_pkg::stage_t st_nxt;
  logic [4:0] r1, r2;
  logic [3:0] ra;
  logic q1, q2;
  logic [scu_pkg::REM_W-1:0] rem_sh, trial;

  always_comb begin
    st_nxt = st_in;
    r1 = {st_in.r, st_in.s[scu_pkg::SUM_W-1]};
    q1 = (r1 >= {1'b0, st_in.d});
    ra = q1 ? 4'(r1 - {1'b0, st_in.d}) : r1[3:0];
    r2 = {ra, st_in.s[scu_pkg::SUM_W-2]};
    q2 = (r2 >= {1'b0, st_in.d});
    st_nxt.r = q2 ? 4'(r2 - {1'b0, st_in.d}) : r2[3:0];
    st_nxt.s = {st_in.s[scu_pkg::SUM_W-3:0], 2'b00};
    rem_sh = {st_in.rem[scu_pkg::REM_W-3:0], q1, q2};
    trial = {st_in.root, 2'b01};
    if (rem_sh >= trial) begin
      st_nxt.rem  = rem_sh - trial;
      st_nxt.root = {st_in.root[scu_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = rem_sh;
      st_nxt.root = {st_in.root[scu_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spectrum_count_uncertainty_top.sv
// Top level of the spectrum count uncertainty block: config register, feed,
// chain of root cells and output register. Depends on scu_pkg, scu_feed, scu_cell.
//
//   channel  | ports            | carries
//   in_      | valid/ready/data | channel count and last mark
//   out_     | valid/ready/data | sigma, smoothed flag, final mark
//   cfg_     | APB write/read   | small count limit at address 0
//
// One channel is taken per cycle unless the output stalls or a last channel is
// still issuing: a last channel issues up to three requests into the chain, one
// per cycle while not stalled. The chain has STEPS cells, 30 at default widths.
// Reset clears the window, the position and all valid flags.
// When a result is not taken the whole chain holds and no input is taken.
`default_nettype none
module spectrum_count_uncertainty_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire scu_pkg::in_data_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output scu_pkg::out_data_t                 out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [scu_pkg::ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  logic [scu_pkg::LIMIT_W-1:0] limit_r;
  logic adv, hit;
  scu_pkg::stage_t st [scu_pkg::STEPS+1];
  scu_pkg::out_data_t res;
  logic [scu_pkg::CMP_W-1:0] root_x;
  logic out_valid_r;
  scu_pkg::out_data_t out_data_r;

  assign cfg_pready = 1'b1;
  assign hit = (cfg_paddr[scu_pkg::ADDR_W-1:2] == scu_pkg::IDX_LIMIT);
  assign cfg_prdata = hit ? 32'(limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= scu_pkg::LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit) begin
      limit_r <= cfg_pwdata[scu_pkg::LIMIT_W-1:0];
    end
  end

  assign adv = !out_valid_r || out_ready;

  scu_feed u_feed (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .limit    (limit_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_r    (st[0])
  );

  for (genvar i = 0; i < scu_pkg::STEPS; i++) begin : g_cell
    scu_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .st_in (st[i]),
      .st_r  (st[i+1])
    );
  end

  always_comb begin
    root_x = scu_pkg::CMP_W'(st[scu_pkg::STEPS].root);
    res.smoothed  = (st[scu_pkg::STEPS].kind != scu_pkg::KIND_PLAIN);
    res.final_res = st[scu_pkg::STEPS].fin;
    if (st[scu_pkg::STEPS].zero) begin
      unique case (st[scu_pkg::STEPS].kind)
        scu_pkg::KIND_PLAIN: res.sigma = scu_pkg::FB_PLAIN;
        scu_pkg::KIND_THREE: res.sigma = scu_pkg::FB_THREE;
        default:             res.sigma = scu_pkg::FB_NINE;
      endcase
    end else if (root_x > scu_pkg::SIGMA_MAX) begin
      res.sigma = scu_pkg::SIGMA_MAX[scu_pkg::SIGMA_W-1:0];
    end else begin
      res.sigma = root_x[scu_pkg::SIGMA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st[scu_pkg::STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
